>>> rtl/core/gse_pkg.sv
// ---------------------------------------------------------------------------
// gse_pkg: shared types and constants of the share embed and extract block.
// Holds the request codes, the field widths and the item that travels down
// the evaluation pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package gse_pkg;

  // Field widths.
  localparam int unsigned PixelBits  = 8;
  localparam int unsigned CoeffBits  = 8;
  localparam int unsigned CoeffsBits = 64;
  localparam int unsigned CountBits  = 4;

  // Largest number of coefficients the pipeline evaluates.
  localparam int unsigned MaxCoeffsDefault = 8;

  // Reset value of the coefficient count register.
  localparam logic [CountBits-1:0] CoeffCountReset = 4'd2;

  // Field reduction polynomial x^8 + x^6 + x^5 + x + 1.
  localparam logic [8:0] GfPoly = 9'h163;

  // Request codes.
  typedef enum logic {
    REQ_EMBED   = 1'b0,
    REQ_EXTRACT = 1'b1
  } req_type_e;

  // One pixel block on its way down the pipeline, with the running
  // Horner accumulator and the coefficient count taken at entry.
  typedef struct packed {
    req_type_e              req;
    logic [PixelBits-1:0]   x;
    logic [PixelBits-1:0]   w;
    logic [PixelBits-1:0]   v;
    logic [PixelBits-1:0]   u;
    logic [CoeffsBits-1:0]  coeffs;
    logic [CountBits-1:0]   k;
    logic [CoeffBits-1:0]   acc;
  } item_t;

endpackage

`default_nettype wire

>>> rtl/core/gse_in_if.sv
// ---------------------------------------------------------------------------
// gse_in_if: request channel carrying one pixel block and its coefficients.
// Valid and ready handshake; a request moves when both are high.
// ---------------------------------------------------------------------------
`default_nettype none

interface gse_in_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic [gse_pkg::PixelBits-1:0]       pixel_x;
  logic [gse_pkg::PixelBits-1:0]       pixel_w;
  logic [gse_pkg::PixelBits-1:0]       pixel_v;
  logic [gse_pkg::PixelBits-1:0]       pixel_u;
  logic [gse_pkg::CoeffsBits-1:0]      coeffs;

  modport source (
    output valid, req_type, pixel_x, pixel_w, pixel_v, pixel_u, coeffs,
    input  ready
  );

  modport sink (
    input  valid, req_type, pixel_x, pixel_w, pixel_v, pixel_u, coeffs,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/gse_out_if.sv
// ---------------------------------------------------------------------------
// gse_out_if: result channel carrying the processed block and share value.
// Valid and ready handshake; a result moves when both are high.
// ---------------------------------------------------------------------------
`default_nettype none

interface gse_out_if;
  logic                                valid;
  logic                                ready;
  logic [gse_pkg::PixelBits-1:0]       out_w;
  logic [gse_pkg::PixelBits-1:0]       out_v;
  logic [gse_pkg::PixelBits-1:0]       out_u;
  logic [gse_pkg::CoeffBits-1:0]       share_value;
  logic                                parity_error;

  modport source (
    output valid, out_w, out_v, out_u, share_value, parity_error,
    input  ready
  );

  modport sink (
    input  valid, out_w, out_v, out_u, share_value, parity_error,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/gse_horner_stage.sv
// ---------------------------------------------------------------------------
// gse_horner_stage: one registered Horner step over GF(256).
// Computes acc * x + s[COEFF_IDX] and holds the item until the next stage
// takes it; coefficients at or above the count are treated as zero.
// ---------------------------------------------------------------------------
`default_nettype none

module gse_horner_stage #(
  parameter int unsigned COEFF_IDX = 0
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire gse_pkg::item_t item_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output gse_pkg::item_t      item_o
);

  // Carry-less multiply of two field elements with reduction.
  function automatic logic [gse_pkg::CoeffBits-1:0] gf_mul(
    input logic [gse_pkg::CoeffBits-1:0] a,
    input logic [gse_pkg::CoeffBits-1:0] b
  );
    logic [gse_pkg::CoeffBits-1:0] p;
    logic [gse_pkg::CoeffBits:0]   aa;
    p  = '0;
    aa = {1'b0, a};
    for (int n = 0; n < gse_pkg::CoeffBits; n++) begin
      if (b[n]) begin
        p = p ^ aa[gse_pkg::CoeffBits-1:0];
      end
      aa = {aa[gse_pkg::CoeffBits-1:0], 1'b0};
      if (aa[gse_pkg::CoeffBits]) begin
        aa = aa ^ gse_pkg::GfPoly;
      end
    end
    return p;
  endfunction

  logic                          valid_q;
  gse_pkg::item_t                item_d, item_q;
  logic [gse_pkg::CoeffBits-1:0] coeff;

  // The stage takes a new item when it is empty or its item moves on.
  assign ready_o = !valid_q || ready_i;

  // Coefficient of this step, zero when beyond the active count.
  always_comb begin
    if (gse_pkg::CountBits'(COEFF_IDX) < item_i.k) begin
      coeff = item_i.coeffs[COEFF_IDX*gse_pkg::CoeffBits +: gse_pkg::CoeffBits];
    end else begin
      coeff = '0;
    end
  end

  // One Horner step on the running accumulator.
  always_comb begin
    item_d     = item_i;
    item_d.acc = gf_mul(item_i.acc, item_i.x) ^ coeff;
  end

  // Valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

>>> rtl/core/gse_pack_stage.sv
// ---------------------------------------------------------------------------
// gse_pack_stage: final stage that embeds the share into the pixel low bits
// or reassembles it from them, checks parity and drives the result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module gse_pack_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire gse_pkg::item_t item_i,
  gse_out_if.source           rsp_o
);

  logic                          valid_q;
  logic [gse_pkg::PixelBits-1:0] w_d, v_d, u_d, w_q, v_q, u_q;
  logic [gse_pkg::CoeffBits-1:0] share_d, share_q;
  logic                          perr_d, perr_q;
  logic [gse_pkg::CoeffBits-1:0] extracted;

  assign ready_o = !valid_q || rsp_o.ready;

  // Value held in the low bits of W, V and U.
  assign extracted = {item_i.w[2:0], item_i.v[2:0], item_i.u[1:0]};

  // Embed or extract the share.
  always_comb begin
    case (item_i.req)
      gse_pkg::REQ_EMBED: begin
        w_d     = {item_i.w[7:3], item_i.acc[7:5]};
        v_d     = {item_i.v[7:3], item_i.acc[4:2]};
        u_d     = {item_i.u[7:3], ^item_i.acc, item_i.acc[1:0]};
        share_d = item_i.acc;
        perr_d  = 1'b0;
      end
      gse_pkg::REQ_EXTRACT: begin
        w_d     = item_i.w;
        v_d     = item_i.v;
        u_d     = item_i.u;
        share_d = extracted;
        perr_d  = item_i.u[2] ^ (^extracted);
      end
      default: begin
        w_d     = item_i.w;
        v_d     = item_i.v;
        u_d     = item_i.u;
        share_d = '0;
        perr_d  = 1'b0;
      end
    endcase
  end

  // Output valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      w_q     <= w_d;
      v_q     <= v_d;
      u_q     <= u_d;
      share_q <= share_d;
      perr_q  <= perr_d;
    end
  end

  assign rsp_o.valid        = valid_q;
  assign rsp_o.out_w        = w_q;
  assign rsp_o.out_v        = v_q;
  assign rsp_o.out_u        = u_q;
  assign rsp_o.share_value  = share_q;
  assign rsp_o.parity_error = perr_q;

endmodule

`default_nettype wire

>>> rtl/core/gf256_share_embed_extract.sv
// ---------------------------------------------------------------------------
// gf256_share_embed_extract: embeds a GF(256) polynomial share into the low
// bits of a 2x2 pixel block, or extracts it and checks its parity bit.
//
//   Channel    Direction  Carries
//   req_i      in         req_type, pixel_x/w/v/u, coeffs
//   rsp_o      out        out_w/v/u, share_value, parity_error
//   coeff_*    in         coefficient count register write
//
// One request enters per cycle while the result channel is ready. There is
// one register stage per Horner step, each holding one GF(256) multiply and
// add, then the packing stage. Every stage has its own valid bit and takes a new
// request when empty or when its content moves on, so bubbles close up under
// a stall. Reset clears the valid bits and sets the coefficient count to 2.
// ---------------------------------------------------------------------------
`default_nettype none

module gf256_share_embed_extract #(
  parameter int unsigned MAX_COEFFS = gse_pkg::MaxCoeffsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          coeff_count_we_i,
  input  wire logic [gse_pkg::CountBits-1:0] coeff_count_i,
  gse_in_if.sink                             req_i,
  gse_out_if.source                          rsp_o
);

  logic [gse_pkg::CountBits-1:0] coeff_count_q;
  logic [gse_pkg::CountBits-1:0] k_sat;

  logic           stage_valid [MAX_COEFFS+1];
  logic           stage_ready [MAX_COEFFS+1];
  gse_pkg::item_t stage_item  [MAX_COEFFS+1];

  // Coefficient count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_count_q <= gse_pkg::CoeffCountReset;
    end else if (coeff_count_we_i) begin
      coeff_count_q <= coeff_count_i;
    end
  end

  // Counts above the pipeline depth saturate.
  assign k_sat = (coeff_count_q > gse_pkg::CountBits'(MAX_COEFFS))
               ? gse_pkg::CountBits'(MAX_COEFFS) : coeff_count_q;

  // Build the pipeline item from the incoming request.
  always_comb begin
    stage_item[0].req    = gse_pkg::req_type_e'(req_i.req_type);
    stage_item[0].x      = req_i.pixel_x;
    stage_item[0].w      = req_i.pixel_w;
    stage_item[0].v      = req_i.pixel_v;
    stage_item[0].u      = req_i.pixel_u;
    stage_item[0].coeffs = req_i.coeffs;
    stage_item[0].k      = k_sat;
    stage_item[0].acc    = '0;
  end

  assign stage_valid[0] = req_i.valid;
  assign req_i.ready    = stage_ready[0];

  // Horner stages, highest coefficient first.
  for (genvar j = 0; j < MAX_COEFFS; j++) begin : g_horner
    gse_horner_stage #(
      .COEFF_IDX (MAX_COEFFS - 1 - j)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[j]),
      .ready_o (stage_ready[j]),
      .item_i  (stage_item[j]),
      .valid_o (stage_valid[j+1]),
      .ready_i (stage_ready[j+1]),
      .item_o  (stage_item[j+1])
    );
  end

  // Packing and output stage.
  gse_pack_stage u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_valid[MAX_COEFFS]),
    .ready_o (stage_ready[MAX_COEFFS]),
    .item_i  (stage_item[MAX_COEFFS]),
    .rsp_o   (rsp_o)
  );

endmodule

`default_nettype wire

>>> tb/gf256_share_embed_extract_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gf256_share_embed_extract_tb: self-checking regression of the share embed
// and extract block.
// A queue of pixel blocks feeds a clocked driver, and a clocked monitor checks
// each response in order against a GF(256) Horner evaluation and bit packer
// kept in the bench. The run steps through coefficient counts between zero
// and fifteen and through phases of sender gaps, receiver stalls and none.
// ---------------------------------------------------------------------------

module gf256_share_embed_extract_tb;
  import gse_pkg::*;

  localparam int unsigned MaxCoeffs  = MaxCoeffsDefault;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned BlocksPerSetting = 62;

  // One pixel block as presented on the request channel.
  typedef struct packed {
    req_type_e             req;
    logic [PixelBits-1:0]  x;
    logic [PixelBits-1:0]  w;
    logic [PixelBits-1:0]  v;
    logic [PixelBits-1:0]  u;
    logic [CoeffsBits-1:0] coeffs;
  } pixel_block_t;

  // The processed block and share value expected on the response channel.
  typedef struct packed {
    logic [PixelBits-1:0] w;
    logic [PixelBits-1:0] v;
    logic [PixelBits-1:0] u;
    logic [CoeffBits-1:0] share;
    logic                 parity_err;
  } share_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic coeff_count_we;
  logic [CountBits-1:0] coeff_count_val;

  gse_in_if  req_if ();
  gse_out_if rsp_if ();

  gf256_share_embed_extract #(
    .MAX_COEFFS (MaxCoeffs)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .coeff_count_we_i (coeff_count_we),
    .coeff_count_i    (coeff_count_val),
    .req_i            (req_if),
    .rsp_o            (rsp_if)
  );

  pixel_block_t  pending_blocks [$];
  share_result_t expected_results [$];
  pixel_block_t  in_flight;
  logic          holding_block = 1'b0;
  logic [CountBits-1:0] coeff_count_cfg = CoeffCountReset;

  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;
  int unsigned results_checked = 0;
  int unsigned embeds_sent    = 0;
  int unsigned extracts_sent  = 0;
  int unsigned parity_flags   = 0;
  int unsigned cycle_count    = 0;

  // Coefficient counts of the random part, one per setting.
  logic [CountBits-1:0] count_plan [12] = '{4'd1, 4'd8, 4'd3, 4'd0, 4'd5, 4'd15,
                                            4'd2, 4'd9, 4'd7, 4'd4, 4'd6, 4'd12};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Multiply in GF(256) reduced by the field polynomial, shift and add.
  function automatic logic [7:0] gf256_mul(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] sh;
    logic [7:0] prod;
    sh   = {1'b0, a};
    prod = 8'h00;
    for (int n = 0; n < 8; n++) begin
      if (b[n]) prod ^= sh[7:0];
      sh = sh << 1;
      if (sh[8]) sh ^= GfPoly;
    end
    return prod;
  endfunction

  // Expected response for one block under the given coefficient count.
  function automatic share_result_t predict_share(input pixel_block_t blk,
                                                  input logic [CountBits-1:0] count);
    share_result_t res;
    int unsigned   k;
    logic [7:0]    t;
    if (blk.req == REQ_EMBED) begin
      k = (32'(count) > MaxCoeffs) ? MaxCoeffs : 32'(count);
      t = 8'h00;
      // Horner evaluation from the highest coefficient in use down to s[0].
      for (int i = k; i > 0; i--) begin
        t = gf256_mul(t, blk.x) ^ blk.coeffs[8*(i-1) +: 8];
      end
      res.w          = {blk.w[7:3], t[7:5]};
      res.v          = {blk.v[7:3], t[4:2]};
      res.u          = {blk.u[7:3], ^t, t[1:0]};
      res.share      = t;
      res.parity_err = 1'b0;
    end else begin
      t              = {blk.w[2:0], blk.v[2:0], blk.u[1:0]};
      res.w          = blk.w;
      res.v          = blk.v;
      res.u          = blk.u;
      res.share      = t;
      res.parity_err = blk.u[2] ^ (^t);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("[%0t] mismatch on %s: got 0x%02h, expected 0x%02h", $time, what, got, want);
  endtask

  task automatic queue_block(input req_type_e req, input logic [7:0] x, input logic [7:0] w,
                             input logic [7:0] v, input logic [7:0] u,
                             input logic [63:0] coeffs);
    pending_blocks.push_back('{req: req, x: x, w: w, v: v, u: u, coeffs: coeffs});
  endtask

  function automatic pixel_block_t random_block();
    pixel_block_t blk;
    blk.req    = ($urandom_range(1) == 1) ? REQ_EXTRACT : REQ_EMBED;
    blk.x      = 8'($urandom_range(255));
    blk.w      = 8'($urandom_range(255));
    blk.v      = 8'($urandom_range(255));
    blk.u      = 8'($urandom_range(255));
    blk.coeffs = {$urandom, $urandom};
    // Now and then put the evaluation point on an extreme value.
    case ($urandom_range(7))
      0: blk.x = 8'h00;
      1: blk.x = 8'h01;
      2: blk.x = 8'hFF;
      default: ;
    endcase
    return blk;
  endfunction

  // Wait until every queued request has gone in and every response come
  // out, then let the pipeline settle for its full depth.
  task automatic drain_pipeline();
    while (pending_blocks.size() != 0 || holding_block || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (MaxCoeffs + 2) @(posedge clk_i);
  endtask

  task automatic write_coeff_count(input logic [CountBits-1:0] value);
    drain_pipeline();
    @(posedge clk_i);
    coeff_count_we  <= 1'b1;
    coeff_count_val <= value;
    @(posedge clk_i);
    coeff_count_we  <= 1'b0;
    coeff_count_cfg = value;
  endtask

  // Request driver: presents the next pending block and records the
  // expected response once the request is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      holding_block = 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_results.push_back(predict_share(in_flight, coeff_count_cfg));
        if (in_flight.req == REQ_EMBED) embeds_sent++;
        else extracts_sent++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_blocks.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_flight = pending_blocks.pop_front();
          holding_block = 1'b1;
          req_if.valid    <= 1'b1;
          req_if.req_type <= in_flight.req;
          req_if.pixel_x  <= in_flight.x;
          req_if.pixel_w  <= in_flight.w;
          req_if.pixel_v  <= in_flight.v;
          req_if.pixel_u  <= in_flight.u;
          req_if.coeffs   <= in_flight.coeffs;
        end else begin
          holding_block = 1'b0;
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: checks each accepted response against the oldest
  // expectation and stalls the response channel at random.
  always @(posedge clk_i or negedge rst_ni) begin
    share_result_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("response with none outstanding", 32'(rsp_if.share_value), 0);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (rsp_if.parity_error) parity_flags++;
          if (rsp_if.out_w !== want.w) begin
            report_mismatch("out_w", 32'(rsp_if.out_w), 32'(want.w));
          end
          if (rsp_if.out_v !== want.v) begin
            report_mismatch("out_v", 32'(rsp_if.out_v), 32'(want.v));
          end
          if (rsp_if.out_u !== want.u) begin
            report_mismatch("out_u", 32'(rsp_if.out_u), 32'(want.u));
          end
          if (rsp_if.share_value !== want.share) begin
            report_mismatch("share_value", 32'(rsp_if.share_value), 32'(want.share));
          end
          if (rsp_if.parity_error !== want.parity_err) begin
            report_mismatch("parity_error", 32'(rsp_if.parity_error),
                            32'(want.parity_err));
          end
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog against a hung pipeline.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[%0t] timed out with %0d responses outstanding", $time,
               expected_results.size());
      $display("gf256_share_embed_extract regression: fail");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    coeff_count_we  = 1'b0;
    coeff_count_val = '0;
    req_if.valid    = 1'b0;
    req_if.req_type = 1'b0;
    req_if.pixel_x  = '0;
    req_if.pixel_w  = '0;
    req_if.pixel_v  = '0;
    req_if.pixel_u  = '0;
    req_if.coeffs   = '0;
    rsp_if.ready    = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed blocks under the reset count of two coefficients.
    queue_block(REQ_EMBED, 8'h00, 8'h00, 8'h00, 8'h00, 64'h0);
    queue_block(REQ_EMBED, 8'h00, 8'hFF, 8'hFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_block(REQ_EMBED, 8'hFF, 8'hAA, 8'hAA, 8'hAA, 64'h0000_0000_0000_A53C);
    // High coefficient bytes beyond the count must be ignored.
    queue_block(REQ_EMBED, 8'h01, 8'h5A, 8'hA5, 8'h3C, 64'h0123_4567_89AB_CDEF);
    queue_block(REQ_EMBED, 8'h02, 8'h07, 8'hF8, 8'h07, 64'hFFFF_FFFF_FFFF_0180);
    queue_block(REQ_EXTRACT, 8'h00, 8'h00, 8'h00, 8'h00, 64'h0);
    // All ones with the parity bit set: the parity check must flag it.
    queue_block(REQ_EXTRACT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_block(REQ_EXTRACT, 8'h00, 8'hFF, 8'hFF, 8'hFB, 64'h0);
    queue_block(REQ_EXTRACT, 8'h80, 8'h01, 8'h00, 8'h04, 64'h0);
    queue_block(REQ_EXTRACT, 8'h80, 8'h01, 8'h00, 8'h00, 64'h0);

    // No coefficients: the share is the empty sum.
    write_coeff_count(4'd0);
    queue_block(REQ_EMBED, 8'h57, 8'h5A, 8'hC3, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_block(REQ_EMBED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 64'h8040_2010_0804_0201);
    queue_block(REQ_EXTRACT, 8'h12, 8'h06, 8'h05, 8'h03, 64'h0);

    // Counts above the pipeline depth saturate.
    write_coeff_count(4'd15);
    queue_block(REQ_EMBED, 8'h02, 8'h11, 8'h22, 8'h33, 64'h0102_0304_0506_0708);
    queue_block(REQ_EMBED, 8'hFF, 8'h00, 8'hFF, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
    write_coeff_count(4'd9);
    queue_block(REQ_EMBED, 8'h80, 8'hF0, 8'h0F, 8'hCC, 64'hDEAD_BEEF_CAFE_F00D);

    write_coeff_count(4'd1);
    queue_block(REQ_EMBED, 8'hFF, 8'h00, 8'h00, 8'h00, 64'hFFFF_FFFF_FFFF_FF3C);
    queue_block(REQ_EMBED, 8'h00, 8'hFF, 8'hFF, 8'hFF, 64'h0000_0000_0000_00FF);

    write_coeff_count(4'd8);
    queue_block(REQ_EMBED, 8'hFF, 8'h81, 8'h42, 8'h24, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_block(REQ_EMBED, 8'h80, 8'h7E, 8'hE7, 8'h18, 64'h8000_0000_0000_0001);

    // Random blocks: receiver stalls first, then sender gaps, then neither.
    for (int s = 0; s < 12; s++) begin
      write_coeff_count(count_plan[s]);
      case (s / 4)
        0: begin
          send_gap_pct   = 10;
          recv_stall_pct = 70;
        end
        1: begin
          send_gap_pct   = 70;
          recv_stall_pct = 10;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int n = 0; n < BlocksPerSetting; n++) pending_blocks.push_back(random_block());
    end

    drain_pipeline();
    $display("Checked %0d responses from %0d embed and %0d extract requests; %0d parity flags.",
             results_checked, embeds_sent, extracts_sent, parity_flags);
    $display("Coefficient counts between 0 and 15 covered, with sender gaps, receiver stalls "
             , "and back-to-back traffic.");
    if (mismatches == 0) begin
      $display("gf256_share_embed_extract regression: pass");
    end else begin
      $display("gf256_share_embed_extract regression: fail");
    end
    $finish;
  end

endmodule
